/* src/sdh_pkg.sv */
// ----------------------------------------------------------------------------
// sdh_pkg: shared types and constants for the SD card SPI host sequencer
// Holds item kinds, status codes, register indexes and the configuration set.
// ----------------------------------------------------------------------------
package sdh_pkg;

    localparam int BLOCK_BYTES   = 512;
    localparam int WAKE_BYTES_DF = 10;
    localparam int QUEUE_DEPTH   = 2;

    // input mode codes
    localparam logic [2:0] MODE_INIT  = 3'd0;
    localparam logic [2:0] MODE_READ  = 3'd1;
    localparam logic [2:0] MODE_WRITE = 3'd2;
    localparam logic [2:0] MODE_CAP   = 3'd3;
    localparam logic [2:0] MODE_BYTE  = 3'd4;
    localparam logic [2:0] MODE_TICK  = 3'd5;

    // register indexes
    localparam logic [2:0] REG_RD_TOK  = 3'd0;
    localparam logic [2:0] REG_BUSY    = 3'd1;
    localparam logic [2:0] REG_PROG    = 3'd2;
    localparam logic [2:0] REG_INIT    = 3'd3;
    localparam logic [2:0] REG_RETRIES = 3'd4;
    localparam logic [2:0] REG_POLLS   = 3'd5;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOCARD = 2'd1;
    localparam logic [1:0] ST_ERR    = 2'd2;
    localparam logic [1:0] ST_TMO    = 2'd3;

    typedef enum logic [2:0] {
        K_INIT, K_READ, K_WRITE, K_CAP, K_BYTE, K_TICK, K_NONE
    } sdh_kind_t;

    typedef struct packed {
        sdh_kind_t    kind;
        logic [7:0]   rx;
        logic [7:0]   wd;
        logic [31:0]  sector;
        logic [15:0]  count;
    } sdh_item_t;

    typedef struct packed {
        logic [15:0] rd_tok_ms;
        logic [15:0] busy_ms;
        logic [15:0] prog_ms;
        logic [15:0] init_ms;
        logic [3:0]  retries;
        logic [7:0]  polls;
    } sdh_cfg_t;

endpackage

/* src/sd_card_spi_host_sequencer_top.sv */
// ----------------------------------------------------------------------------
// sd_card_spi_host_sequencer_top: SPI-mode SD card host sequencer
// Drives card init, block reads and writes and the capacity query, at most
// one SPI byte exchange per result.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (valid/ready) carries one item: a request, a finished byte
//   exchange with the received byte, or a millisecond tick. res channel
//   (valid/ready) returns at most one result per item: the next byte to send
//   with chip select and clock speed, a read payload byte, or the end of a
//   request with status, card kind and sector count. Ticks and ignored items
//   give no result.
//   An accepted item waits in an entry of the two-entry item queue, then the
//   sequencer handles it and writes its result into the result register. The
//   sequencer takes one item per cycle, so items flow back to back while the
//   result register is free or being taken.
//   When the receiver stalls, the result register holds and the queue fills;
//   req_ready drops when both queue entries are full.
//   Reset returns the sequencer to idle, slow clock, no card, and loads the
//   timeout, retry and poll registers with their defaults.
// ----------------------------------------------------------------------------
module sd_card_spi_host_sequencer_top #(
    parameter int WAKE_BYTES = sdh_pkg::WAKE_BYTES_DF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_data,
    input  logic         req_valid,
    output logic         req_ready,
    input  logic [2:0]   mode,
    input  logic [7:0]   rx_byte,
    input  logic [7:0]   write_data,
    input  logic [31:0]  start_sector,
    input  logic [15:0]  block_count,
    output logic         res_valid,
    input  logic         res_ready,
    output logic [7:0]   tx_byte,
    output logic         tx_valid,
    output logic         chip_select,
    output logic         fast_clock,
    output logic         need_payload,
    output logic [7:0]   read_byte,
    output logic         read_valid,
    output logic         done_res,
    output logic [1:0]   status,
    output logic [1:0]   card_kind,
    output logic [31:0]  sector_count
);
    import sdh_pkg::*;

    sdh_cfg_t   cfg_reg;
    sdh_item_t  q_item;
    logic       q_valid, q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rd_tok_ms <= 16'd500;
            cfg_reg.busy_ms   <= 16'd500;
            cfg_reg.prog_ms   <= 16'd1000;
            cfg_reg.init_ms   <= 16'd2000;
            cfg_reg.retries   <= 4'd5;
            cfg_reg.polls     <= 8'd10;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_RD_TOK:  cfg_reg.rd_tok_ms <= cfg_data;
                REG_BUSY:    cfg_reg.busy_ms   <= cfg_data;
                REG_PROG:    cfg_reg.prog_ms   <= cfg_data;
                REG_INIT:    cfg_reg.init_ms   <= cfg_data;
                REG_RETRIES: cfg_reg.retries   <= cfg_data[3:0];
                REG_POLLS:   cfg_reg.polls     <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    sdh_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .mode         (mode),
        .rx_byte      (rx_byte),
        .write_data   (write_data),
        .start_sector (start_sector),
        .block_count  (block_count),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop)
    );

    sdh_back #(
        .WAKE_BYTES (WAKE_BYTES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .tx_byte      (tx_byte),
        .tx_valid     (tx_valid),
        .chip_select  (chip_select),
        .fast_clock   (fast_clock),
        .need_payload (need_payload),
        .read_byte    (read_byte),
        .read_valid   (read_valid),
        .done_res     (done_res),
        .status       (status),
        .card_kind    (card_kind),
        .sector_count (sector_count)
    );

    // a request end never starts an exchange
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && done_res |-> !tx_valid && chip_select && !need_payload)
        else $error("request end carries an exchange");

    a_payload_sel: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && need_payload |-> tx_valid && !chip_select)
        else $error("payload request without selected exchange");

    a_read_exch: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && read_valid |-> tx_valid && !done_res && !chip_select)
        else $error("read byte outside a data exchange");

    a_sectors: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && sector_count != 32'd0 |-> done_res && status == ST_OK)
        else $error("sector count outside successful end");

endmodule

/* src/sdh_front.sv */
// ----------------------------------------------------------------------------
// sdh_front: input stage and item queue
// Accepts items, decodes the mode into a kind, drops unused modes and
// queues the rest for the sequencer.
// ----------------------------------------------------------------------------
module sdh_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  logic [2:0]          mode,
    input  logic [7:0]          rx_byte,
    input  logic [7:0]          write_data,
    input  logic [31:0]         start_sector,
    input  logic [15:0]         block_count,
    output logic                q_valid,
    output sdh_pkg::sdh_item_t  q_item,
    input  logic                q_pop
);
    import sdh_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    sdh_item_t       mem [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]     count_reg, count_next;
    sdh_kind_t       kind;
    logic            push;

    always_comb
    begin
        unique case (mode)
            MODE_INIT:  kind = K_INIT;
            MODE_READ:  kind = K_READ;
            MODE_WRITE: kind = K_WRITE;
            MODE_CAP:   kind = K_CAP;
            MODE_BYTE:  kind = K_BYTE;
            MODE_TICK:  kind = K_TICK;
            default:    kind = K_NONE;
        endcase
    end

    assign req_ready = (count_reg != (PW+1)'(QUEUE_DEPTH));
    // drop unused modes at the door
    assign push      = req_valid && req_ready && (kind != K_NONE);
    assign q_valid   = (count_reg != '0);
    assign q_item    = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !(q_pop && q_valid))
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop && q_valid)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (q_pop && q_valid)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= '{kind: kind, rx: rx_byte, wd: write_data,
                                 sector: start_sector, count: block_count};
        end
    end

endmodule

/* src/sdh_back.sv */
// ----------------------------------------------------------------------------
// sdh_back: card sequencer and result register
// Carries out queued items against the command sequence state, one per cycle
// while the result register is free, and holds each result until it is taken.
// ----------------------------------------------------------------------------
module sdh_back #(
    parameter int WAKE_BYTES = sdh_pkg::WAKE_BYTES_DF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sdh_pkg::sdh_cfg_t   cfg,
    input  logic                q_valid,
    input  sdh_pkg::sdh_item_t  q_item,
    output logic                q_pop,
    output logic                res_valid,
    input  logic                res_ready,
    output logic [7:0]          tx_byte,
    output logic                tx_valid,
    output logic                chip_select,
    output logic                fast_clock,
    output logic                need_payload,
    output logic [7:0]          read_byte,
    output logic                read_valid,
    output logic                done_res,
    output logic [1:0]          status,
    output logic [1:0]          card_kind,
    output logic [31:0]         sector_count
);
    import sdh_pkg::*;

    typedef enum logic [1:0] { PH_IDLE, PH_CMD, PH_POLL, PH_X } phase_t;
    typedef enum logic [1:0] { OP_INIT, OP_READ, OP_WRITE, OP_CAP } op_t;
    typedef enum logic [5:0] {
        A_WAKE, A_CMD0, A_CMD0X, A_NOCARD, A_CMD8GO, A_CMD8, A_R7, A_R7CHK,
        A_V2_41, A_V2_41R, A_V2_CHK, A_CMD58, A_OCR, A_SETLEN, A_CMD16, A_CMD16CHK,
        A_V1GO, A_V1_41, A_V1_41R, A_V1_CHK1, A_V1L_41, A_V1L_R, A_V1L_CHK,
        A_RD1, A_RDM, A_RDNEXT, A_TOK, A_RDATA, A_CRC, A_STOPOK, A_STOPF,
        A_WR1, A_WRM, A_WRNEXT, A_RDY, A_WTOKEN, A_WDATA, A_WCRC, A_WRESP,
        A_STOPTOK, A_STOPSENT, A_OKTAIL, A_CSD, A_CAPDONE, A_OK, A_ERR, A_TMO
    } act_t;

    localparam logic [9:0] BLK  = 10'(BLOCK_BYTES);
    localparam logic [9:0] WAKE = 10'(WAKE_BYTES);

    phase_t       phase_reg, phase_next;
    act_t         act_reg, act_next, wait_reg, wait_next, a2, nxt;
    op_t          op_reg, op_next;
    logic         multi_reg, multi_next;
    logic [1:0]   kind_reg, kind_next;
    logic         fast_reg, fast_next;
    logic [47:0]  shift_reg, shift_next, shift_tmp;
    logic [31:0]  resp_reg, resp_next;
    logic [63:0]  csd_reg [2];
    logic [63:0]  csd_next [2];
    logic [9:0]   bc_reg, bc_next, b;
    logic [15:0]  blocks_reg, blocks_next;
    logic [7:0]   poll_reg, poll_next;
    logic [3:0]   retry_reg, retry_next;
    logic [15:0]  dl_reg, dl_next;
    logic [7:0]   r1_reg, r1_next;

    logic         do_cmd, do_xb, do_fin, do_emit, run_go, produce;
    logic [5:0]   cmd_c;
    logic [31:0]  cmd_arg, addr;
    logic [7:0]   cmd_crc, xb_tx, emit_tx, x, rd_b;
    logic         xb_cs, xb_need, rd_v;
    logic [1:0]   fin_st;
    logic [31:0]  sectors;

    function automatic logic [7:0] csd_byte(logic [63:0] w0, logic [63:0] w1,
                                            logic [3:0] k);
        logic [63:0] w;
        w = k[3] ? w1 : w0;
        w = w << {k[2:0], 3'b000};
        return w[63:56];
    endfunction

    function automatic logic [31:0] csd_sectors(logic [63:0] w0, logic [63:0] w1);
        logic [21:0]        c22;
        logic [32:0]        s33;
        logic [11:0]        c12;
        logic [12:0]        v;
        logic [2:0]         m;
        logic signed [5:0]  e;
        logic [5:0]         ne;
        logic [31:0]        r;
        if (csd_byte(w0, w1, 4'd0)[7:6] == 2'b01)
        begin
            c22 = {csd_byte(w0, w1, 4'd7)[5:0], csd_byte(w0, w1, 4'd8),
                   csd_byte(w0, w1, 4'd9)};
            s33 = (33'(c22) + 33'd1) << 10;
            r   = s33[32] ? 32'hFFFF_FFFF : s33[31:0];
        end
        else
        begin
            c12 = {csd_byte(w0, w1, 4'd6)[1:0], csd_byte(w0, w1, 4'd7),
                   csd_byte(w0, w1, 4'd8)[7:6]};
            m   = {csd_byte(w0, w1, 4'd9)[1:0], csd_byte(w0, w1, 4'd10)[7]};
            v   = 13'(c12) + 13'd1;
            e   = $signed({3'b000, m}) + $signed({2'b00, csd_byte(w0, w1, 4'd5)[3:0]})
                  - 6'sd7;
            ne  = 6'(-e);
            if (e >= 0)
            begin
                r = 32'(v) << e[3:0];
            end
            else
            begin
                r = 32'(v >> ne[2:0]);
            end
        end
        return r;
    endfunction

    assign q_pop = q_valid && (!res_valid || res_ready);

    always_comb
    begin
        phase_next  = phase_reg;   act_next   = act_reg;   wait_next = wait_reg;
        op_next     = op_reg;      multi_next = multi_reg; kind_next = kind_reg;
        fast_next   = fast_reg;    shift_next = shift_reg; resp_next = resp_reg;
        csd_next[0] = csd_reg[0];  csd_next[1] = csd_reg[1];
        bc_next     = bc_reg;      blocks_next = blocks_reg; poll_next = poll_reg;
        retry_next  = retry_reg;   dl_next    = dl_reg;    r1_next   = r1_reg;
        do_cmd = 1'b0; do_xb = 1'b0; do_fin = 1'b0; do_emit = 1'b0; run_go = 1'b0;
        cmd_c = '0; cmd_arg = '0; cmd_crc = 8'h01; xb_tx = 8'hFF; xb_cs = 1'b0;
        xb_need = 1'b0; emit_tx = 8'hFF; fin_st = ST_OK; nxt = act_reg;
        rd_b = '0; rd_v = 1'b0; sectors = '0; x = q_item.rx; b = '0; a2 = act_reg;
        shift_tmp = '0; addr = '0;

        if (q_pop)
        begin
            case (q_item.kind)
                K_INIT, K_READ, K_WRITE, K_CAP:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        if (q_item.kind == K_INIT)
                        begin
                            op_next = OP_INIT; kind_next = 2'd0; fast_next = 1'b0;
                            bc_next = '0;
                            do_xb = 1'b1; xb_cs = 1'b1; nxt = A_WAKE;
                        end
                        else if (q_item.kind == K_CAP)
                        begin
                            op_next = OP_CAP; multi_next = 1'b0;
                            do_cmd = 1'b1; cmd_c = 6'd9; nxt = A_CSD;
                        end
                        else
                        begin
                            addr = (kind_reg == 2'd3) ? q_item.sector
                                                      : {q_item.sector[22:0], 9'b0};
                            blocks_next = q_item.count;
                            multi_next  = (q_item.count != 16'd1);
                            do_cmd  = 1'b1;
                            cmd_arg = addr;
                            if (q_item.kind == K_READ)
                            begin
                                op_next = OP_READ;
                                cmd_c = multi_next ? 6'd18 : 6'd17;
                                nxt   = multi_next ? A_RDM : A_RD1;
                            end
                            else
                            begin
                                op_next = OP_WRITE;
                                cmd_c = multi_next ? 6'd25 : 6'd24;
                                nxt   = multi_next ? A_WRM : A_WR1;
                            end
                        end
                    end
                end
                K_TICK:
                begin
                    if (dl_reg != '0)
                    begin
                        dl_next = dl_reg - 1'b1;
                    end
                end
                K_BYTE:
                begin
                    unique case (phase_reg)
                        PH_CMD:
                        begin
                            b = bc_reg + 1'b1;
                            bc_next = b;
                            if (b < 10'd6)
                            begin
                                shift_tmp = shift_reg << {b[2:0], 3'b000};
                                do_emit = 1'b1; emit_tx = shift_tmp[47:40];
                            end
                            else
                            begin
                                poll_next = '0;
                                if (cfg.polls == '0)
                                begin
                                    r1_next = 8'hFF; x = 8'hFF; run_go = 1'b1;
                                end
                                else
                                begin
                                    phase_next = PH_POLL; do_emit = 1'b1;
                                end
                            end
                        end
                        PH_POLL:
                        begin
                            if (!x[7])
                            begin
                                r1_next = x; run_go = 1'b1;
                            end
                            else
                            begin
                                poll_next = poll_reg + 1'b1;
                                if (poll_next >= cfg.polls)
                                begin
                                    r1_next = 8'hFF; x = 8'hFF; run_go = 1'b1;
                                end
                                else
                                begin
                                    do_emit = 1'b1;
                                end
                            end
                        end
                        PH_X:    run_go = 1'b1;
                        default: ;
                    endcase
                end
                default: ;
            endcase

            if (run_go)
            begin
                // resolve actions that fall straight through to another one
                a2 = act_reg;
                if (act_reg == A_RDY && x == 8'hFF)
                begin
                    a2 = wait_reg;
                end
                else if (act_reg == A_V1L_CHK && r1_next == 8'h00)
                begin
                    a2 = A_SETLEN;
                end
                else if (act_reg == A_RDM && x == 8'h00)
                begin
                    a2 = A_RDNEXT;
                end
                else if (act_reg == A_WRM && x == 8'h00)
                begin
                    a2 = A_WRNEXT;
                end
                else if (act_reg == A_CRC && (bc_next + 1'b1) >= 10'd2 &&
                         op_reg != OP_CAP && multi_reg)
                begin
                    bc_next = bc_next + 1'b1;
                    blocks_next = blocks_next - 1'b1;
                    a2 = A_RDNEXT;
                end
                else if (act_reg == A_WRESP && x[4:0] == 5'h05 && multi_reg)
                begin
                    blocks_next = blocks_next - 1'b1;
                    a2 = A_WRNEXT;
                end

                unique case (a2)
                    A_WAKE:
                    begin
                        b = bc_next + 1'b1; bc_next = b;
                        if (b < WAKE)
                        begin
                            do_xb = 1'b1; xb_cs = 1'b1; nxt = A_WAKE;
                        end
                        else
                        begin
                            retry_next = '0;
                            if (cfg.retries == '0)
                            begin
                                do_xb = 1'b1; xb_cs = 1'b1; nxt = A_NOCARD;
                            end
                            else
                            begin
                                do_cmd = 1'b1; cmd_c = 6'd0; nxt = A_CMD0;
                            end
                        end
                    end
                    A_CMD0:
                    begin
                        do_xb = 1'b1;
                        xb_cs = (x == 8'h01);
                        nxt   = (x == 8'h01) ? A_CMD8GO : A_CMD0X;
                    end
                    A_CMD0X:
                    begin
                        retry_next = retry_next + 1'b1;
                        if (retry_next < cfg.retries)
                        begin
                            do_cmd = 1'b1; cmd_c = 6'd0; nxt = A_CMD0;
                        end
                        else
                        begin
                            do_xb = 1'b1; xb_cs = 1'b1; nxt = A_NOCARD;
                        end
                    end
                    A_NOCARD:
                    begin
                        do_fin = 1'b1; fin_st = ST_NOCARD;
                    end
                    A_CMD8GO:
                    begin
                        do_cmd = 1'b1; cmd_c = 6'd8; cmd_arg = 32'h0000_01AA; nxt = A_CMD8;
                    end
                    A_CMD8:
                    begin
                        do_xb = 1'b1;
                        if (x == 8'h01)
                        begin
                            bc_next = '0; resp_next = '0; nxt = A_R7;
                        end
                        else
                        begin
                            xb_cs = 1'b1; nxt = A_V1GO;
                        end
                    end
                    A_R7, A_OCR:
                    begin
                        resp_next = {resp_next[23:0], x};
                        b = bc_next + 1'b1; bc_next = b;
                        do_xb = 1'b1;
                        if (b < 10'd4)
                        begin
                            nxt = a2;
                        end
                        else
                        begin
                            xb_cs = 1'b1;
                            if (a2 == A_R7)
                            begin
                                nxt = A_R7CHK;
                            end
                            else
                            begin
                                kind_next = resp_next[30] ? 2'd3 : 2'd2;
                                nxt = A_SETLEN;
                            end
                        end
                    end
                    A_R7CHK:
                    begin
                        if (resp_next[15:8] != 8'h01 || resp_next[7:0] != 8'hAA)
                        begin
                            do_fin = 1'b1; fin_st = ST_ERR;
                        end
                        else
                        begin
                            dl_next = cfg.init_ms;
                            do_cmd = 1'b1; cmd_c = 6'd55; nxt = A_V2_41;
                        end
                    end
                    A_V2_41:
                    begin
                        do_cmd = 1'b1; cmd_c = 6'd41; cmd_arg = 32'h4000_0000; nxt = A_V2_41R;
                    end
                    A_V2_41R:
                    begin
                        do_xb = 1'b1; xb_cs = 1'b1; nxt = A_V2_CHK;
                    end
                    A_V2_CHK, A_V1L_CHK:
                    begin
                        if (a2 == A_V2_CHK && r1_next == 8'h00)
                        begin
                            do_cmd = 1'b1; cmd_c = 6'd58; nxt = A_CMD58;
                        end
                        else if (dl_next == '0)
                        begin
                            do_fin = 1'b1; fin_st = ST_TMO;
                        end
                        else
                        begin
                            do_cmd = 1'b1; cmd_c = 6'd55;
                            nxt = (a2 == A_V2_CHK) ? A_V2_41 : A_V1L_41;
                        end
                    end
                    A_CMD58:
                    begin
                        do_xb = 1'b1;
                        if (x == 8'h00)
                        begin
                            bc_next = '0; resp_next = '0; nxt = A_OCR;
                        end
                        else
                        begin
                            xb_cs = 1'b1; nxt = A_SETLEN;
                        end
                    end
                    A_SETLEN:
                    begin
                        if (kind_next == 2'd3)
                        begin
                            fast_next = 1'b1; do_fin = 1'b1; fin_st = ST_OK;
                        end
                        else
                        begin
                            do_cmd = 1'b1; cmd_c = 6'd16; cmd_arg = 32'(BLOCK_BYTES);
                            nxt = A_CMD16;
                        end
                    end
                    A_CMD16:
                    begin
                        do_xb = 1'b1; xb_cs = 1'b1; nxt = A_CMD16CHK;
                    end
                    A_CMD16CHK:
                    begin
                        do_fin = 1'b1;
                        if (r1_next != 8'h00)
                        begin
                            fin_st = ST_ERR;
                        end
                        else
                        begin
                            fast_next = 1'b1; fin_st = ST_OK;
                        end
                    end
                    A_V1GO:
                    begin
                        do_cmd = 1'b1; cmd_c = 6'd55; nxt = A_V1_41;
                    end
                    A_V1_41:
                    begin
                        do_cmd = 1'b1; cmd_c = 6'd41; nxt = A_V1_41R;
                    end
                    A_V1_41R:
                    begin
                        do_xb = 1'b1; xb_cs = 1'b1; nxt = A_V1_CHK1;
                    end
                    A_V1_CHK1:
                    begin
                        if (r1_next <= 8'h01)
                        begin
                            kind_next = 2'd1; dl_next = cfg.init_ms;
                            do_cmd = 1'b1; cmd_c = 6'd55; nxt = A_V1L_41;
                        end
                        else
                        begin
                            do_fin = 1'b1; fin_st = ST_ERR;
                        end
                    end
                    A_V1L_41:
                    begin
                        do_cmd = 1'b1; cmd_c = 6'd41; nxt = A_V1L_R;
                    end
                    A_V1L_R:
                    begin
                        do_xb = 1'b1; xb_cs = 1'b1; nxt = A_V1L_CHK;
                    end
                    A_RD1, A_CSD:
                    begin
                        do_xb = 1'b1;
                        if (x != 8'h00)
                        begin
                            xb_cs = 1'b1; nxt = A_ERR;
                        end
                        else
                        begin
                            dl_next = cfg.rd_tok_ms; nxt = A_TOK;
                        end
                    end
                    A_RDM, A_WRM:
                    begin
                        do_xb = 1'b1; xb_cs = 1'b1; nxt = A_ERR;
                    end
                    A_RDNEXT:
                    begin
                        if (blocks_next == '0)
                        begin
                            do_cmd = 1'b1; cmd_c = 6'd12; nxt = A_STOPOK;
                        end
                        else
                        begin
                            dl_next = cfg.rd_tok_ms; do_xb = 1'b1; nxt = A_TOK;
                        end
                    end
                    A_TOK:
                    begin
                        if (x == 8'hFE)
                        begin
                            bc_next = '0; do_xb = 1'b1; nxt = A_RDATA;
                        end
                        else if (x != 8'hFF || dl_next == '0)
                        begin
                            if (op_reg == OP_READ && multi_reg)
                            begin
                                do_cmd = 1'b1; cmd_c = 6'd12; nxt = A_STOPF;
                            end
                            else
                            begin
                                do_xb = 1'b1; xb_cs = 1'b1; nxt = A_TMO;
                            end
                        end
                        else
                        begin
                            do_xb = 1'b1; nxt = A_TOK;
                        end
                    end
                    A_RDATA:
                    begin
                        if (op_reg == OP_CAP)
                        begin
                            csd_next[bc_next[3]] = {csd_reg[bc_next[3]][55:0], x};
                        end
                        else
                        begin
                            rd_b = x; rd_v = 1'b1;
                        end
                        b = bc_next + 1'b1; bc_next = b;
                        do_xb = 1'b1;
                        if (b < ((op_reg == OP_CAP) ? 10'd16 : BLK))
                        begin
                            nxt = A_RDATA;
                        end
                        else
                        begin
                            bc_next = '0; nxt = A_CRC;
                        end
                    end
                    A_CRC:
                    begin
                        b = bc_next + 1'b1; bc_next = b;
                        do_xb = 1'b1;
                        if (b < 10'd2)
                        begin
                            nxt = A_CRC;
                        end
                        else
                        begin
                            xb_cs = 1'b1;
                            nxt = (op_reg == OP_CAP) ? A_CAPDONE : A_OK;
                        end
                    end
                    A_STOPOK:
                    begin
                        do_xb = 1'b1; xb_cs = 1'b1; nxt = A_OK;
                    end
                    A_STOPF:
                    begin
                        do_xb = 1'b1; xb_cs = 1'b1; nxt = A_TMO;
                    end
                    A_WR1:
                    begin
                        do_xb = 1'b1;
                        if (x != 8'h00)
                        begin
                            xb_cs = 1'b1; nxt = A_ERR;
                        end
                        else
                        begin
                            dl_next = cfg.busy_ms; wait_next = A_WTOKEN; nxt = A_RDY;
                        end
                    end
                    A_WRNEXT:
                    begin
                        dl_next = cfg.busy_ms; do_xb = 1'b1; nxt = A_RDY;
                        wait_next = (blocks_next == '0) ? A_STOPTOK : A_WTOKEN;
                    end
                    A_RDY:
                    begin
                        do_xb = 1'b1;
                        if (dl_next == '0)
                        begin
                            xb_cs = 1'b1; nxt = A_TMO;
                        end
                        else
                        begin
                            nxt = A_RDY;
                        end
                    end
                    A_WTOKEN:
                    begin
                        bc_next = '0; do_xb = 1'b1; xb_need = 1'b1; nxt = A_WDATA;
                        xb_tx = multi_reg ? 8'hFC : 8'hFE;
                    end
                    A_WDATA:
                    begin
                        do_xb = 1'b1;
                        if (bc_next < BLK)
                        begin
                            b = bc_next + 1'b1; bc_next = b;
                            xb_tx = q_item.wd; xb_need = (b < BLK); nxt = A_WDATA;
                        end
                        else
                        begin
                            bc_next = '0; nxt = A_WCRC;
                        end
                    end
                    A_WCRC:
                    begin
                        b = bc_next + 1'b1; bc_next = b;
                        do_xb = 1'b1;
                        nxt = (b < 10'd2) ? A_WCRC : A_WRESP;
                    end
                    A_WRESP:
                    begin
                        do_xb = 1'b1;
                        if (x[4:0] != 5'h05)
                        begin
                            xb_cs = 1'b1; nxt = A_ERR;
                        end
                        else
                        begin
                            dl_next = cfg.prog_ms; wait_next = A_OKTAIL; nxt = A_RDY;
                        end
                    end
                    A_STOPTOK:
                    begin
                        do_xb = 1'b1; xb_tx = 8'hFD; nxt = A_STOPSENT;
                    end
                    A_STOPSENT:
                    begin
                        dl_next = cfg.prog_ms; wait_next = A_OKTAIL;
                        do_xb = 1'b1; nxt = A_RDY;
                    end
                    A_OKTAIL:
                    begin
                        do_xb = 1'b1; xb_cs = 1'b1; nxt = A_OK;
                    end
                    A_CAPDONE:
                    begin
                        sectors = csd_sectors(csd_reg[0], csd_reg[1]);
                        do_fin = 1'b1; fin_st = ST_OK;
                    end
                    A_OK:
                    begin
                        do_fin = 1'b1; fin_st = ST_OK;
                    end
                    A_ERR:
                    begin
                        do_fin = 1'b1; fin_st = ST_ERR;
                    end
                    default:
                    begin
                        do_fin = 1'b1; fin_st = ST_TMO;
                    end
                endcase
            end

            cmd_crc = (cmd_c == 6'd0) ? 8'h95 : (cmd_c == 6'd8) ? 8'h87 : 8'h01;
            if (do_cmd)
            begin
                shift_next = {8'h40 | {2'b00, cmd_c}, cmd_arg, cmd_crc};
                bc_next    = '0;
                act_next   = nxt;
                phase_next = PH_CMD;
            end
            else if (do_xb)
            begin
                act_next   = nxt;
                phase_next = PH_X;
            end
            else if (do_fin)
            begin
                phase_next = PH_IDLE;
            end
        end
    end

    assign produce = do_cmd || do_xb || do_fin || do_emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            act_reg    <= A_WAKE;
            wait_reg   <= A_WAKE;
            op_reg     <= OP_INIT;
            multi_reg  <= 1'b0;
            kind_reg   <= '0;
            fast_reg   <= 1'b0;
            shift_reg  <= '0;
            resp_reg   <= '0;
            bc_reg     <= '0;
            blocks_reg <= '0;
            poll_reg   <= '0;
            retry_reg  <= '0;
            dl_reg     <= '0;
            r1_reg     <= '0;
            res_valid  <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            act_reg    <= act_next;
            wait_reg   <= wait_next;
            op_reg     <= op_next;
            multi_reg  <= multi_next;
            kind_reg   <= kind_next;
            fast_reg   <= fast_next;
            shift_reg  <= shift_next;
            resp_reg   <= resp_next;
            bc_reg     <= bc_next;
            blocks_reg <= blocks_next;
            poll_reg   <= poll_next;
            retry_reg  <= retry_next;
            dl_reg     <= dl_next;
            r1_reg     <= r1_next;
            if (q_pop && produce)
            begin
                res_valid <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid <= 1'b0;
            end
        end
    end

    // result payload and card data store need no reset
    always_ff @(posedge clk)
    begin
        csd_reg[0] <= csd_next[0];
        csd_reg[1] <= csd_next[1];
        if (q_pop && produce)
        begin
            tx_byte      <= do_fin ? 8'h00 : (do_cmd ? (8'h40 | {2'b00, cmd_c})
                                            : (do_emit ? emit_tx : xb_tx));
            tx_valid     <= !do_fin;
            chip_select  <= do_fin || (do_xb && xb_cs);
            need_payload <= do_xb && xb_need;
            fast_clock   <= fast_next;
            read_byte    <= rd_b;
            read_valid   <= rd_v;
            done_res     <= do_fin;
            status       <= do_fin ? fin_st : ST_OK;
            card_kind    <= kind_next;
            sector_count <= sectors;
        end
    end

endmodule
